// File: rtl/slide_capture_relay_sequencer_unit_defines.svh
// Assertion macros for the slide capture relay sequencer
`ifndef SLIDE_CAPTURE_RELAY_SEQUENCER_UNIT_DEFINES_SVH
`define SLIDE_CAPTURE_RELAY_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication, reset masked
`define SCRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define SCRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/scrs_pkg.sv
// Types and constants shared by the slide capture relay sequencer
package scrs_pkg;

    localparam int unsigned AddrWidth = 5;

    localparam logic [2:0] REG_SHUTTER_TICKS = 3'd0;
    localparam logic [2:0] REG_SETTLE_TICKS  = 3'd1;
    localparam logic [2:0] REG_ADVANCE_TICKS = 3'd2;
    localparam logic [2:0] REG_RELOAD_TICKS  = 3'd3;
    localparam logic [2:0] REG_PRESET_SMALL  = 3'd4;
    localparam logic [2:0] REG_PRESET_MEDIUM = 3'd5;
    localparam logic [2:0] REG_PRESET_LARGE  = 3'd6;

    typedef struct packed {
        logic play_press;
        logic count_press;
    } in_item_t;

    typedef struct packed {
        logic       camera_relay;
        logic       advance_relay;
        logic       playing_shown;
        logic [7:0] slides_left;
        logic [1:0] hundreds_digit;
        logic [3:0] tens_digit;
        logic [3:0] ones_digit;
        logic       blank_hundreds;
        logic       blank_tens;
        logic [1:0] scan_position;
    } out_item_t;

    typedef struct packed {
        logic [1:0] hundreds;
        logic [3:0] tens;
        logic [3:0] ones;
    } digits_t;

endpackage

// File: rtl/scrs_digits.sv
// Binary to decimal digit split of the 8-bit slide count
module scrs_digits (
    input  logic [7:0]       value,
    output scrs_pkg::digits_t digits
);

    logic [1:0]  hund;
    logic [7:0]  rem;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [7:0]  tens_x10;

    always_comb begin
        if (value >= 8'd200) begin
            hund = 2'd2;
            rem  = value - 8'd200;
        end else if (value >= 8'd100) begin
            hund = 2'd1;
            rem  = value - 8'd100;
        end else begin
            hund = 2'd0;
            rem  = value;
        end
    end

    // divide by ten through the reciprocal 205/2048, exact below 1029
    assign prod     = {7'd0, rem} * 15'd205;
    assign tens     = prod[14:11];
    assign tens_x10 = {1'b0, tens, 3'd0} + {3'd0, tens, 1'b0};

    assign digits.hundreds = hund;
    assign digits.tens     = tens;
    assign digits.ones     = 4'(rem - tens_x10);

endmodule

// File: rtl/slide_capture_relay_sequencer_unit.sv
// Top level of the slide capture relay sequencer
// Latency: a result appears in the cycle after its input transfer.
// Throughput: one tick per cycle while the result register frees as it
// drains; phase timer, count and scan index update in one registered step.
// Reset (aresetn low, synchronous): phase 0, timer 255, stopped, count 80,
// scan index 0, timing and preset registers back to their defaults.
`include "slide_capture_relay_sequencer_unit_defines.svh"

module slide_capture_relay_sequencer_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [scrs_pkg::AddrWidth-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  scrs_pkg::in_item_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output scrs_pkg::out_item_t               m_data
);

    typedef enum logic [1:0] {
        PH_SHUTTER = 2'd0,
        PH_SETTLE  = 2'd1,
        PH_ADVANCE = 2'd2,
        PH_RELOAD  = 2'd3
    } phase_t;

    logic [15:0] shutter_ticks_reg;
    logic [15:0] settle_ticks_reg;
    logic [15:0] advance_ticks_reg;
    logic [15:0] reload_ticks_reg;
    logic [7:0]  preset_small_reg;
    logic [7:0]  preset_medium_reg;
    logic [7:0]  preset_large_reg;

    phase_t      phase_reg, phase_next;
    logic [15:0] timer_reg, timer_next;
    logic        running_reg, running_next;
    logic [7:0]  total_reg, total_next;
    logic [1:0]  scan_index_reg;

    logic                m_valid_reg;
    scrs_pkg::out_item_t m_data_reg, m_data_next;
    scrs_pkg::digits_t   digits;

    logic        accept;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [15:0] timer_dec;
    logic        expired;
    logic        cam, adv;
    logic [7:0]  total_after;
    logic        running_after;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[scrs_pkg::AddrWidth-1:2];

    always_comb begin
        unique case (cfg_index)
            scrs_pkg::REG_SHUTTER_TICKS: prdata = {16'd0, shutter_ticks_reg};
            scrs_pkg::REG_SETTLE_TICKS:  prdata = {16'd0, settle_ticks_reg};
            scrs_pkg::REG_ADVANCE_TICKS: prdata = {16'd0, advance_ticks_reg};
            scrs_pkg::REG_RELOAD_TICKS:  prdata = {16'd0, reload_ticks_reg};
            scrs_pkg::REG_PRESET_SMALL:  prdata = {24'd0, preset_small_reg};
            scrs_pkg::REG_PRESET_MEDIUM: prdata = {24'd0, preset_medium_reg};
            scrs_pkg::REG_PRESET_LARGE:  prdata = {24'd0, preset_large_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shutter_ticks_reg <= 16'd255;
            settle_ticks_reg  <= 16'd512;
            advance_ticks_reg <= 16'd255;
            reload_ticks_reg  <= 16'd2048;
            preset_small_reg  <= 8'd36;
            preset_medium_reg <= 8'd80;
            preset_large_reg  <= 8'd140;
        end else if (cfg_write) begin
            unique case (cfg_index)
                scrs_pkg::REG_SHUTTER_TICKS: shutter_ticks_reg <= pwdata[15:0];
                scrs_pkg::REG_SETTLE_TICKS:  settle_ticks_reg  <= pwdata[15:0];
                scrs_pkg::REG_ADVANCE_TICKS: advance_ticks_reg <= pwdata[15:0];
                scrs_pkg::REG_RELOAD_TICKS:  reload_ticks_reg  <= pwdata[15:0];
                scrs_pkg::REG_PRESET_SMALL:  preset_small_reg  <= pwdata[7:0];
                scrs_pkg::REG_PRESET_MEDIUM: preset_medium_reg <= pwdata[7:0];
                scrs_pkg::REG_PRESET_LARGE:  preset_large_reg  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    scrs_digits u_digits (
        .value  (total_reg),
        .digits (digits)
    );

    assign timer_dec = (timer_reg != 16'd0) ? timer_reg - 16'd1 : 16'd0;
    assign expired   = (timer_dec == 16'd0);

    always_comb begin
        phase_next    = phase_reg;
        timer_next    = timer_reg;
        total_after   = total_reg;
        running_after = running_reg;
        cam           = 1'b0;
        adv           = 1'b0;
        if (running_reg) begin
            timer_next = timer_dec;
            unique case (phase_reg)
                PH_SHUTTER: begin
                    cam = 1'b1;
                    if (expired) begin
                        phase_next = PH_SETTLE;
                        timer_next = settle_ticks_reg;
                    end
                end
                PH_SETTLE: begin
                    if (expired) begin
                        phase_next = PH_ADVANCE;
                        timer_next = advance_ticks_reg;
                    end
                end
                PH_ADVANCE: begin
                    adv = 1'b1;
                    if (expired) begin
                        phase_next = PH_RELOAD;
                        timer_next = reload_ticks_reg;
                    end
                end
                PH_RELOAD: begin
                    if (expired) begin
                        total_after = total_reg - 8'd1;
                        phase_next  = PH_SHUTTER;
                        timer_next  = shutter_ticks_reg;
                        if (total_after == 8'd0) begin
                            running_after = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end

        running_next = running_after ^ s_data.play_press;
        total_next   = total_after;
        if (s_data.count_press) begin
            running_next = 1'b0;
            if (total_after < preset_small_reg) begin
                total_next = preset_small_reg;
            end else if (total_after < preset_medium_reg) begin
                total_next = preset_medium_reg;
            end else if (total_after < preset_large_reg) begin
                total_next = preset_large_reg;
            end else begin
                total_next = preset_small_reg;
            end
        end

        m_data_next.camera_relay   = cam;
        m_data_next.advance_relay  = adv;
        m_data_next.playing_shown  = running_reg;
        m_data_next.slides_left    = total_reg;
        m_data_next.hundreds_digit = digits.hundreds;
        m_data_next.tens_digit     = digits.tens;
        m_data_next.ones_digit     = digits.ones;
        m_data_next.blank_hundreds = (digits.hundreds == 2'd0);
        m_data_next.blank_tens     = (digits.hundreds == 2'd0) && (digits.tens == 4'd0);
        m_data_next.scan_position  = scan_index_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_SHUTTER;
            timer_reg      <= 16'd255;
            running_reg    <= 1'b0;
            total_reg      <= 8'd80;
            scan_index_reg <= 2'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg      <= phase_next;
                timer_reg      <= timer_next;
                running_reg    <= running_next;
                total_reg      <= total_next;
                scan_index_reg <= scan_index_reg + 2'd1;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SCRS_ASSERT_NOW(a_relays_exclusive, m_valid_reg,
        !(m_data_reg.camera_relay && m_data_reg.advance_relay),
        "camera and advance relays both energized")
    `SCRS_ASSERT_NOW(a_relays_need_play, m_valid_reg,
        m_data_reg.playing_shown || (!m_data_reg.camera_relay && !m_data_reg.advance_relay),
        "relay energized while stopped")
    `SCRS_ASSERT_NEXT(a_count_press_stops, accept && s_data.count_press, !running_reg,
        "count press did not stop play")
    `SCRS_ASSERT_NEXT(a_scan_advances, accept,
        scan_index_reg == $past(scan_index_reg) + 2'd1,
        "scan index did not advance on transfer")

endmodule

// File: verif/tb_slide_capture_relay_sequencer_unit.sv
// Self-checking testbench for the slide capture relay sequencer: predicted ticks vs. results
module tb_slide_capture_relay_sequencer_unit;

    typedef enum logic [1:0] {
        PH_SHUTTER,
        PH_SETTLE,
        PH_ADVANCE,
        PH_RELOAD
    } phase_t;

    logic                           aclk    = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [scrs_pkg::AddrWidth-1:0] paddr   = '0;
    logic [31:0]                    pwdata  = '0;
    logic [31:0]                    prdata;
    logic                           pready;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    scrs_pkg::in_item_t             s_data  = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b1;
    scrs_pkg::out_item_t            m_data;

    logic [15:0] cfg_shutter = 16'd255;
    logic [15:0] cfg_settle  = 16'd512;
    logic [15:0] cfg_advance = 16'd255;
    logic [15:0] cfg_reload  = 16'd2048;
    logic [7:0]  cfg_small   = 8'd36;
    logic [7:0]  cfg_medium  = 8'd80;
    logic [7:0]  cfg_large   = 8'd140;

    phase_t      seq_phase   = PH_SHUTTER;
    logic [15:0] seq_timer   = 16'd255;
    logic        seq_running = 1'b0;
    logic [7:0]  seq_count   = 8'd80;
    logic [1:0]  seq_scan    = 2'd0;

    scrs_pkg::out_item_t pending_results[$];
    int                  mismatch_count = 0;
    int                  max_gap        = 16;
    int                  stall_left     = 0;

    slide_capture_relay_sequencer_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #1 aclk = ~aclk;

    function automatic scrs_pkg::out_item_t predict_tick(input scrs_pkg::in_item_t t);
        scrs_pkg::out_item_t r;
        int shown;
        shown = seq_count;
        r.camera_relay   = 1'b0;
        r.advance_relay  = 1'b0;
        r.playing_shown  = seq_running;
        r.slides_left    = seq_count;
        r.hundreds_digit = 2'(shown / 100);
        r.tens_digit     = 4'((shown / 10) % 10);
        r.ones_digit     = 4'(shown % 10);
        r.blank_hundreds = (shown < 100);
        r.blank_tens     = (shown < 10);
        r.scan_position  = seq_scan;
        if (seq_running) begin
            if (seq_timer != 16'd0)
                seq_timer = seq_timer - 16'd1;
            case (seq_phase)
                PH_SHUTTER: begin
                    r.camera_relay = 1'b1;
                    if (seq_timer == 16'd0) begin
                        seq_phase = PH_SETTLE;
                        seq_timer = cfg_settle;
                    end
                end
                PH_SETTLE: begin
                    if (seq_timer == 16'd0) begin
                        seq_phase = PH_ADVANCE;
                        seq_timer = cfg_advance;
                    end
                end
                PH_ADVANCE: begin
                    r.advance_relay = 1'b1;
                    if (seq_timer == 16'd0) begin
                        seq_phase = PH_RELOAD;
                        seq_timer = cfg_reload;
                    end
                end
                default: begin
                    if (seq_timer == 16'd0) begin
                        seq_count = seq_count - 8'd1;
                        seq_phase = PH_SHUTTER;
                        seq_timer = cfg_shutter;
                        if (seq_count == 8'd0)
                            seq_running = 1'b0;
                    end
                end
            endcase
        end
        seq_scan = seq_scan + 2'd1;
        if (t.play_press)
            seq_running = !seq_running;
        if (t.count_press) begin
            seq_running = 1'b0;
            if (seq_count < cfg_small)
                seq_count = cfg_small;
            else if (seq_count < cfg_medium)
                seq_count = cfg_medium;
            else if (seq_count < cfg_large)
                seq_count = cfg_large;
            else
                seq_count = cfg_small;
        end
        return r;
    endfunction

    task automatic flag_field(input string field, input logic [7:0] want_v,
                              input logic [7:0] got_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on %s: expected %0h, got %0h", field, want_v, got_v);
    endtask

    always @(posedge aclk) begin : check_results
        scrs_pkg::out_item_t want;
        scrs_pkg::out_item_t got;
        int stall;
        if (aresetn && m_valid && m_ready) begin
            got = m_data;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result transfer with nothing pending: %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got.camera_relay !== want.camera_relay)
                    flag_field("camera_relay", 8'(want.camera_relay),
                               8'(got.camera_relay));
                if (got.advance_relay !== want.advance_relay)
                    flag_field("advance_relay", 8'(want.advance_relay),
                               8'(got.advance_relay));
                if (got.playing_shown !== want.playing_shown)
                    flag_field("playing_shown", 8'(want.playing_shown),
                               8'(got.playing_shown));
                if (got.slides_left !== want.slides_left)
                    flag_field("slides_left", want.slides_left, got.slides_left);
                if (got.hundreds_digit !== want.hundreds_digit)
                    flag_field("hundreds_digit", 8'(want.hundreds_digit),
                               8'(got.hundreds_digit));
                if (got.tens_digit !== want.tens_digit)
                    flag_field("tens_digit", 8'(want.tens_digit), 8'(got.tens_digit));
                if (got.ones_digit !== want.ones_digit)
                    flag_field("ones_digit", 8'(want.ones_digit), 8'(got.ones_digit));
                if (got.blank_hundreds !== want.blank_hundreds)
                    flag_field("blank_hundreds", 8'(want.blank_hundreds),
                               8'(got.blank_hundreds));
                if (got.blank_tens !== want.blank_tens)
                    flag_field("blank_tens", 8'(want.blank_tens), 8'(got.blank_tens));
                if (got.scan_position !== want.scan_position)
                    flag_field("scan_position", 8'(want.scan_position),
                               8'(got.scan_position));
            end
            stall = $urandom_range(0, max_gap);
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall_left = stall;
            end
        end else if (stall_left > 0) begin
            stall_left--;
            if (stall_left == 0)
                m_ready <= 1'b1;
        end
    end

    task automatic send_tick(input logic play, input logic cnt);
        int gap;
        scrs_pkg::in_item_t item;
        gap = $urandom_range(0, max_gap);
        item.play_press  = play;
        item.count_press = cnt;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        pending_results.push_back(predict_tick(item));
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic release_input();
        s_valid <= 1'b0;
    endtask

    task automatic drain_results();
        do @(posedge aclk); while (pending_results.size() != 0);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            scrs_pkg::REG_SHUTTER_TICKS: cfg_shutter = value[15:0];
            scrs_pkg::REG_SETTLE_TICKS:  cfg_settle  = value[15:0];
            scrs_pkg::REG_ADVANCE_TICKS: cfg_advance = value[15:0];
            scrs_pkg::REG_RELOAD_TICKS:  cfg_reload  = value[15:0];
            scrs_pkg::REG_PRESET_SMALL:  cfg_small   = value[7:0];
            scrs_pkg::REG_PRESET_MEDIUM: cfg_medium  = value[7:0];
            scrs_pkg::REG_PRESET_LARGE:  cfg_large   = value[7:0];
            default: ;
        endcase
    endtask

    task automatic write_timing(input int shutter, input int settle, input int advance,
                                input int reload);
        write_reg(scrs_pkg::REG_SHUTTER_TICKS, shutter);
        write_reg(scrs_pkg::REG_SETTLE_TICKS, settle);
        write_reg(scrs_pkg::REG_ADVANCE_TICKS, advance);
        write_reg(scrs_pkg::REG_RELOAD_TICKS, reload);
    endtask

    task automatic write_presets(input int lo, input int mid, input int hi);
        write_reg(scrs_pkg::REG_PRESET_SMALL, lo);
        write_reg(scrs_pkg::REG_PRESET_MEDIUM, mid);
        write_reg(scrs_pkg::REG_PRESET_LARGE, hi);
    endtask

    function automatic int pick_preset();
        case ($urandom_range(0, 3))
            0:       return 1;
            1:       return 255;
            default: return $urandom_range(1, 255);
        endcase
    endfunction

    task automatic test_defaults();
        max_gap = 16;
        repeat (3) send_tick(1'b0, 1'b0);
        repeat (3) send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        repeat (3) send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        release_input();
    endtask

    task automatic test_preset_stepping();
        drain_results();
        write_presets(255, 1, 128);
        repeat (4) send_tick(1'b0, 1'b1);
        release_input();
        drain_results();
        write_presets(200, 100, 50);
        repeat (3) send_tick(1'b0, 1'b1);
        release_input();
    endtask

    // run down to zero, then restart at zero and let the count wrap
    task automatic test_zero_count_wrap();
        int n;
        drain_results();
        write_timing(1, 1, 1, 1);
        write_presets(1, 2, 3);
        while (seq_count != 8'd1)
            send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        n = 0;
        while (seq_running && n < 1000) begin
            send_tick(1'b0, 1'b0);
            n++;
        end
        send_tick(1'b1, 1'b0);
        n = 0;
        while (seq_count != 8'd255 && n < 1000) begin
            send_tick(1'b0, 1'b0);
            n++;
        end
        send_tick(1'b1, 1'b0);
        repeat (3) send_tick(1'b0, 1'b0);
        release_input();
    endtask

    task automatic test_random_ticks();
        int hold_at;
        for (int round = 0; round < 4; round++) begin
            drain_results();
            max_gap = (round % 2 == 0) ? 16 : 0;
            if (round == 3)
                write_timing($urandom_range(1, 400), $urandom_range(1, 400),
                             $urandom_range(1, 400), $urandom_range(1, 400));
            else
                write_timing($urandom_range(1, 12), $urandom_range(1, 12),
                             $urandom_range(1, 12), $urandom_range(1, 12));
            write_presets(pick_preset(), pick_preset(), pick_preset());
            hold_at = $urandom_range(50, 180);
            for (int i = 0; i < 220; i++) begin
                if (i == hold_at) begin
                    release_input();
                    do @(posedge aclk); while (pending_results.size() != 0);
                end
                send_tick($urandom_range(0, 15) == 0, $urandom_range(0, 39) == 0);
            end
            release_input();
        end
    endtask

    // load full-length phases and run ticks back to back
    task automatic test_long_phase();
        int changes;
        int n;
        phase_t last;
        drain_results();
        max_gap = 0;
        write_timing(65535, 65535, 65535, 65535);
        changes = 0;
        n = 0;
        while (changes < 2 && n < 60) begin
            last = seq_phase;
            send_tick(!seq_running, 1'b0);
            if (seq_phase != last)
                changes++;
            n++;
        end
        release_input();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_defaults();
        test_preset_stepping();
        test_zero_count_wrap();
        test_random_ticks();
        test_long_phase();
        drain_results();
        repeat (4) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
